### hdl/prht_pkg.sv
// Package for the point region hit test pipeline.
// Holds coordinate widths, the shape codes and the stage payload structs.
// No dependencies.
package prht_pkg;

    localparam int CW = 16;          // coordinate width
    localparam int DW = CW + 1;      // difference of two coordinates
    localparam int PW = 2 * DW;      // product of two differences
    localparam int SW = PW + 1;      // sum of two products
    localparam int NW = PW + 3;      // det - na - nb
    localparam int TDATA_W = 8 * CW; // eight coordinates in the input word
    localparam int TUSER_W = 2;
    localparam int MDATA_W = 8;

    typedef enum logic [1:0] {
        SHAPE_RECT   = 2'd0,
        SHAPE_CIRCLE = 2'd1,
        SHAPE_TRI    = 2'd2,
        SHAPE_NONE   = 2'd3
    } t_shape;

    // after the difference stage
    typedef struct packed {
        t_shape                 shape;
        logic                   rect_hit;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic signed [CW-1:0]   rad;
        logic signed [DW-1:0]   e1;
        logic signed [DW-1:0]   e2;
        logic signed [DW-1:0]   e3;
        logic signed [DW-1:0]   e4;
        logic signed [DW-1:0]   qx;
        logic signed [DW-1:0]   qy;
    } t_diff;

    // after the product stage
    typedef struct packed {
        t_shape                 shape;
        logic                   rect_hit;
        logic signed [PW-1:0]   dxx;
        logic signed [PW-1:0]   dyy;
        logic signed [PW-1:0]   rr;
        logic signed [PW-1:0]   e1e4;
        logic signed [PW-1:0]   e2e3;
        logic signed [PW-1:0]   e1qx;
        logic signed [PW-1:0]   e2qy;
        logic signed [PW-1:0]   e3qx;
        logic signed [PW-1:0]   e4qy;
    } t_prod;

    // after the sum stage
    typedef struct packed {
        t_shape                 shape;
        logic                   rect_hit;
        logic                   circ_hit;
        logic signed [SW-1:0]   det;
        logic signed [SW-1:0]   na;
        logic signed [SW-1:0]   nb;
    } t_sum;

endpackage

### hdl/prht_diff.sv
// Stage 1: coordinate differences and the complete rectangle test.
// Depends on prht_pkg.
module prht_diff
    import prht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_en,
    input  logic [TDATA_W-1:0] i_data,  // point_x, point_y, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
    input  logic [TUSER_W-1:0] i_user,  // shape
    output logic               o_valid,
    output t_diff              o_data
);

    logic signed [DW-1:0] px, py, ax, ay, bx, by, cx, cy;
    logic signed [DW:0]   dx2, dy2, bx2, by2;
    t_diff                n_data;
    t_diff                r_data;
    logic                 r_valid;

    always_comb begin
        px = DW'($signed(i_data[0*CW +: CW]));
        py = DW'($signed(i_data[1*CW +: CW]));
        ax = DW'($signed(i_data[2*CW +: CW]));
        ay = DW'($signed(i_data[3*CW +: CW]));
        bx = DW'($signed(i_data[4*CW +: CW]));
        by = DW'($signed(i_data[5*CW +: CW]));
        cx = DW'($signed(i_data[6*CW +: CW]));
        cy = DW'($signed(i_data[7*CW +: CW]));

        n_data.shape = t_shape'(i_user);
        n_data.dx    = px - ax;
        n_data.dy    = py - ay;
        n_data.rad   = i_data[4*CW +: CW];
        n_data.e1    = by - cy;
        n_data.e2    = cx - bx;
        n_data.e3    = cy - ay;
        n_data.e4    = ax - cx;
        n_data.qx    = px - cx;
        n_data.qy    = py - cy;

        // |2*d| <= size, edges inside; a negative size gives an empty interval
        dx2 = {n_data.dx, 1'b0};
        dy2 = {n_data.dy, 1'b0};
        bx2 = (DW+1)'(bx);
        by2 = (DW+1)'(by);
        n_data.rect_hit = (dx2 >= -bx2) && (dx2 <= bx2) && (dy2 >= -by2) && (dy2 <= by2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hdl/prht_mul.sv
// Stage 2: all products for the circle and triangle tests, in parallel.
// Depends on prht_pkg.
module prht_mul
    import prht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_en,
    input  t_diff i_data,
    output logic  o_valid,
    output t_prod o_data
);

    t_prod                n_data;
    t_prod                r_data;
    logic                 r_valid;
    logic signed [DW-1:0] rad;

    always_comb begin
        rad             = DW'(i_data.rad);
        n_data.shape    = i_data.shape;
        n_data.rect_hit = i_data.rect_hit;
        n_data.dxx      = i_data.dx * i_data.dx;
        n_data.dyy      = i_data.dy * i_data.dy;
        n_data.rr       = rad * rad;
        n_data.e1e4     = i_data.e1 * i_data.e4;
        n_data.e2e3     = i_data.e2 * i_data.e3;
        n_data.e1qx     = i_data.e1 * i_data.qx;
        n_data.e2qy     = i_data.e2 * i_data.qy;
        n_data.e3qx     = i_data.e3 * i_data.qx;
        n_data.e4qy     = i_data.e4 * i_data.qy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hdl/prht_sum.sv
// Stage 3: product sums, circle compare, determinant and two numerators.
// Depends on prht_pkg.
module prht_sum
    import prht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_en,
    input  t_prod i_data,
    output logic  o_valid,
    output t_sum  o_data
);

    t_sum                 n_data;
    t_sum                 r_data;
    logic                 r_valid;
    logic signed [SW-1:0] d2;

    always_comb begin
        n_data.shape    = i_data.shape;
        n_data.rect_hit = i_data.rect_hit;
        d2              = SW'(i_data.dxx) + SW'(i_data.dyy);
        n_data.circ_hit = SW'(i_data.rr) >= d2;
        // ay - cy is -e3, so det = e1*e4 - e2*e3
        n_data.det      = SW'(i_data.e1e4) - SW'(i_data.e2e3);
        n_data.na       = SW'(i_data.e1qx) + SW'(i_data.e2qy);
        n_data.nb       = SW'(i_data.e3qx) + SW'(i_data.e4qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hdl/prht_dec.sv
// Stage 4: third numerator, sign agreement and shape select into the output register.
// Depends on prht_pkg.
module prht_dec
    import prht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_en,
    input  t_sum i_data,
    output logic o_valid,
    output logic o_hit
);

    logic signed [NW-1:0] nc;
    logic                 d_neg, d_pos;
    logic                 a_ok, b_ok, c_ok;
    logic                 n_hit;
    logic                 r_hit;
    logic                 r_valid;

    always_comb begin
        nc    = NW'(i_data.det) - NW'(i_data.na) - NW'(i_data.nb);
        d_neg = i_data.det[SW-1];
        d_pos = !d_neg && (i_data.det != '0);
        // numerator agrees when zero or of the determinant's sign
        a_ok  = d_neg ? (i_data.na[SW-1] || i_data.na == '0) : !i_data.na[SW-1];
        b_ok  = d_neg ? (i_data.nb[SW-1] || i_data.nb == '0) : !i_data.nb[SW-1];
        c_ok  = d_neg ? (nc[NW-1] || nc == '0) : !nc[NW-1];

        case (i_data.shape)
            SHAPE_RECT:   n_hit = i_data.rect_hit;
            SHAPE_CIRCLE: n_hit = i_data.circ_hit;
            SHAPE_TRI:    n_hit = (d_neg || d_pos) && a_ok && b_ok && c_ok;
            SHAPE_NONE:   n_hit = 1'b0;
            default:      n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

### hdl/point_region_hit_test_unit.sv
// Point region hit test: rectangle, circle or triangle against one query point.
// Registered stages from input accept to m_axis_tvalid: diff, mul, sum, decide.
// Throughput: one word per cycle; each stage advances when the next stage is
// empty or advancing, so bubbles collapse and a stall holds every word in place.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; no other state.
module point_region_hit_test_unit
    import prht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // point_x, point_y, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
    input  logic [TUSER_W-1:0] s_axis_tuser,  // shape
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [MDATA_W-1:0] m_axis_tdata   // hit, zero pad
);

    logic  v1, v2, v3, v4;
    logic  en1, en2, en3, en4;
    t_diff d1;
    t_prod d2;
    t_sum  d3;
    logic  hit;

    assign en4 = !v4 || m_axis_tready;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;

    prht_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_en    (en1),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .o_valid (v1),
        .o_data  (d1)
    );

    prht_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_en    (en2),
        .i_data  (d1),
        .o_valid (v2),
        .o_data  (d2)
    );

    prht_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .i_en    (en3),
        .i_data  (d2),
        .o_valid (v3),
        .o_data  (d3)
    );

    prht_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .i_en    (en4),
        .i_data  (d3),
        .o_valid (v4),
        .o_hit   (hit)
    );

    assign s_axis_tready = en1;
    assign m_axis_tvalid = v4;
    assign m_axis_tdata  = {{(MDATA_W-1){1'b0}}, hit};

endmodule

### tb/point_region_hit_test_unit_tb.sv
// Testbench for point_region_hit_test_unit: directed and random hit queries
// checked against an in-bench hit predictor. Depends on prht_pkg and the RTL.
module point_region_hit_test_unit_tb
    import prht_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 1430;
    localparam int PIPE_DEPTH  = 4;

    typedef struct packed {
        logic signed [CW-1:0] p2_y;
        logic signed [CW-1:0] p2_x;
        logic signed [CW-1:0] p1_y;
        logic signed [CW-1:0] p1_x;
        logic signed [CW-1:0] p0_y;
        logic signed [CW-1:0] p0_x;
        logic signed [CW-1:0] pt_y;
        logic signed [CW-1:0] pt_x;
        t_shape               shape;
    } t_hit_query;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;   // pt_x, pt_y, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
    logic [TUSER_W-1:0] s_axis_tuser;   // shape
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [MDATA_W-1:0] m_axis_tdata;   // hit, zero pad

    t_hit_query query_queue[$];
    logic       hit_expect[$];
    t_hit_query drv_item;
    logic       word_taken;
    logic       rx_hold;
    int         in_count;
    int         err_cnt;
    int         cycle_cnt;

    point_region_hit_test_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Exact integer hit test; widths stay well inside 64 bits.
    function automatic logic region_hit(t_hit_query q);
        longint px, py, ax, ay, bx, by, cx, cy;
        longint dx, dy, e1, e2, e3, e4, qx, qy, det, na, nb, nc;
        logic   hit;
        px = longint'(q.pt_x); py = longint'(q.pt_y);
        ax = longint'(q.p0_x); ay = longint'(q.p0_y);
        bx = longint'(q.p1_x); by = longint'(q.p1_y);
        cx = longint'(q.p2_x); cy = longint'(q.p2_y);
        hit = 1'b0;
        case (q.shape)
            SHAPE_RECT: begin
                // compare doubled offsets against full width/height
                dx = 2 * (px - ax);
                dy = 2 * (py - ay);
                hit = (dx >= -bx) && (dx <= bx) && (dy >= -by) && (dy <= by);
            end
            SHAPE_CIRCLE: begin
                dx = px - ax;
                dy = py - ay;
                hit = (bx * bx) >= (dx * dx + dy * dy);
            end
            SHAPE_TRI: begin
                e1 = by - cy; e2 = cx - bx; e3 = cy - ay; e4 = ax - cx;
                qx = px - cx; qy = py - cy;
                det = e1 * (ax - cx) + e2 * (ay - cy);
                if (det != 0) begin
                    na = e1 * qx + e2 * qy;
                    nb = e3 * qx + e4 * qy;
                    nc = det - na - nb;
                    hit = (na == 0 || ((na < 0) == (det < 0)))
                       && (nb == 0 || ((nb < 0) == (det < 0)))
                       && (nc == 0 || ((nc < 0) == (det < 0)));
                end
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    task automatic add_query(input t_shape sh,
                             input logic signed [CW-1:0] px, py,
                             input logic signed [CW-1:0] ax, ay,
                             input logic signed [CW-1:0] bx, by,
                             input logic signed [CW-1:0] cx, cy);
        t_hit_query q;
        q.shape = sh;
        q.pt_x = px; q.pt_y = py;
        q.p0_x = ax; q.p0_y = ay;
        q.p1_x = bx; q.p1_y = by;
        q.p2_x = cx; q.p2_y = cy;
        query_queue.push_back(q);
    endtask

    function automatic logic signed [CW-1:0] jitter(logic signed [CW-1:0] base, int span);
        int off;
        off = $urandom_range(0, 2 * span);
        off = off - span;
        return base + CW'(off);
    endfunction

    function automatic logic signed [CW-1:0] mid_coord();
        int v;
        v = $urandom_range(0, 16000);
        return CW'(v - 8000);
    endfunction

    task automatic add_random_query();
        t_hit_query q;
        int         pick;
        int         k;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            // raw noise over the whole field range
            q.shape = t_shape'($urandom_range(0, 3));
            q.pt_x = CW'($urandom); q.pt_y = CW'($urandom);
            q.p0_x = CW'($urandom); q.p0_y = CW'($urandom);
            q.p1_x = CW'($urandom); q.p1_y = CW'($urandom);
            q.p2_x = CW'($urandom); q.p2_y = CW'($urandom);
        end else begin
            q.p0_x = mid_coord();
            q.p0_y = mid_coord();
            q.p2_x = CW'($urandom);
            q.p2_y = CW'($urandom);
            if (pick < 45) begin
                q.shape = SHAPE_RECT;
                q.p1_x = jitter(CW'(30), 40);
                q.p1_y = jitter(CW'(30), 40);
                q.pt_x = jitter(q.p0_x, 40);
                q.pt_y = jitter(q.p0_y, 40);
            end else if (pick < 70) begin
                q.shape = SHAPE_CIRCLE;
                q.p1_x = jitter(CW'(0), 60);
                q.p1_y = CW'($urandom);
                q.pt_x = jitter(q.p0_x, 60);
                q.pt_y = jitter(q.p0_y, 60);
            end else if (pick < 95) begin
                q.shape = SHAPE_TRI;
                q.p1_x = jitter(q.p0_x, 200);
                q.p1_y = jitter(q.p0_y, 200);
                if ($urandom_range(0, 9) == 0) begin
                    // collinear vertices
                    k = $urandom_range(0, 2);
                    q.p2_x = q.p0_x + CW'(k) * (q.p1_x - q.p0_x);
                    q.p2_y = q.p0_y + CW'(k) * (q.p1_y - q.p0_y);
                end else begin
                    q.p2_x = jitter(q.p0_x, 200);
                    q.p2_y = jitter(q.p0_y, 200);
                end
                q.pt_x = jitter(q.p0_x, 200);
                q.pt_y = jitter(q.p0_y, 200);
            end else begin
                q.shape = SHAPE_NONE;
                q.p1_x = 16'sd100;
                q.p1_y = 16'sd100;
                q.pt_x = q.p0_x;
                q.pt_y = q.p0_y;
            end
        end
        query_queue.push_back(q);
    endtask

    task automatic wait_drained();
        while (query_queue.size() != 0 || s_axis_tvalid || hit_expect.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic quiet_window();
        return cycle_cnt >= 1200 && cycle_cnt < 1700;
    endfunction

    // sender: hold the word until taken, otherwise offer the next one or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (query_queue.size() != 0
                    && (quiet_window() || $urandom_range(0, 99) >= 25)) begin
                drv_item = query_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {drv_item.p2_y, drv_item.p2_x, drv_item.p1_y,
                                  drv_item.p1_x, drv_item.p0_y, drv_item.p0_x,
                                  drv_item.pt_y, drv_item.pt_x};
                s_axis_tuser  <= drv_item.shape;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && (quiet_window() || $urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin : monitor
        logic want;
        word_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (word_taken) begin
            hit_expect.push_back(region_hit(drv_item));
            in_count++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hit_expect.size() == 0) begin
                $error("unexpected result word: hit actual %0b", m_axis_tdata[0]);
                err_cnt++;
            end else begin
                want = hit_expect.pop_front();
                if (m_axis_tdata[0] !== want) begin
                    $error("hit mismatch: expected %0b, actual %0b", want, m_axis_tdata[0]);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // long output stall while the sender keeps offering words
    initial begin
        rx_hold = 1'b0;
        while (in_count < 400)
            @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (150) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        word_taken    = 1'b0;
        drv_item      = '0;
        in_count      = 0;
        err_cnt       = 0;
        cycle_cnt     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rectangle: edges inside, just past an edge, empty and zero-size boxes
        add_query(SHAPE_RECT, 10, 5, 0, 0, 20, 10, 0, 0);
        add_query(SHAPE_RECT, 11, 5, 0, 0, 20, 10, 0, 0);
        add_query(SHAPE_RECT, -10, -5, 0, 0, 20, 10, 0, 0);
        add_query(SHAPE_RECT, 0, 0, 0, 0, -2, 10, 0, 0);
        add_query(SHAPE_RECT, 0, 0, 0, 0, 0, 0, 0, 0);
        // circle: on the rim, just outside, negative radius
        add_query(SHAPE_CIRCLE, 3, 4, 0, 0, 5, 0, 0, 0);
        add_query(SHAPE_CIRCLE, 4, 4, 0, 0, 5, 0, 0, 0);
        add_query(SHAPE_CIRCLE, 3, 4, 0, 0, -5, 0, 0, 0);
        // triangle: inside, on an edge, outside, other winding, a vertex, degenerate
        add_query(SHAPE_TRI, 10, 10, 0, 0, 100, 0, 0, 100);
        add_query(SHAPE_TRI, 50, 50, 0, 0, 100, 0, 0, 100);
        add_query(SHAPE_TRI, 51, 50, 0, 0, 100, 0, 0, 100);
        add_query(SHAPE_TRI, 10, 10, 0, 0, 0, 100, 100, 0);
        add_query(SHAPE_TRI, 0, 0, 0, 0, 0, 100, 100, 0);
        add_query(SHAPE_TRI, 50, 50, 0, 0, 50, 50, 100, 100);
        add_query(SHAPE_NONE, 0, 0, 0, 0, 100, 100, 0, 0);
        // field extremes
        for (int s = 0; s < 4; s++) begin
            add_query(t_shape'(s), 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                      16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
            add_query(t_shape'(s), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        end
        add_query(SHAPE_CIRCLE, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                  16'sh8000, 0, 0, 0);
        add_query(SHAPE_TRI, 0, 0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh8000, 16'sh7fff);
        add_query(SHAPE_RECT, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 0, 0);
        wait_drained();

        for (int i = 0; i < RAND_ITEMS / 2; i++)
            add_random_query();
        // sender pauses here until the pipeline has emptied
        wait_drained();
        for (int i = RAND_ITEMS / 2; i < RAND_ITEMS; i++)
            add_random_query();
        wait_drained();

        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
